// ===== rtl/stpc_pkg.sv =====
// Shared constants for the parity-count segment tree: field layout and request codes.
package stpc_pkg;

    // Field widths of one request and one result.
    localparam int REQ_W   = 2;
    localparam int POS_W   = 10;
    localparam int VAL_W   = 32;
    localparam int COUNT_W = 11;
    localparam int CFG_W   = 11;

    // Packed stream widths; the data widths are rounded up to whole bytes.
    localparam int IN_DATA_W  = 64;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 16;
    localparam int OUT_USER_W = 1;

    // Bit offsets of the request fields inside s_tdata.
    localparam int POS_LSB = 0;
    localparam int VAL_LSB = POS_LSB + POS_W;
    localparam int LO_LSB  = VAL_LSB + VAL_W;
    localparam int HI_LSB  = LO_LSB + POS_W;

    // Request kinds carried on s_tuser.
    localparam logic [REQ_W-1:0] REQ_UPDATE = 2'd0;
    localparam logic [REQ_W-1:0] REQ_EVEN   = 2'd1;
    localparam logic [REQ_W-1:0] REQ_ODD    = 2'd2;

    // Result status codes.
    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_ERR = 1'b1;

    // Entry count after reset.
    localparam logic [CFG_W-1:0] CFG_RESET = 11'd1024;

endpackage

// ===== rtl/segment_tree_parity_count.sv =====
// Top level: segment tree of even-value counts with point update and range count.
//
//  Channel   Dir  Handshake                    Payload
//  s_*       in   s_tvalid / s_tready          tuser: req_type; tdata: pos, value, lo, hi
//  m_*       out  m_tvalid / m_tready          tdata: count; tuser: status
//  cfg_*     in   cfg_valid / cfg_ready        cfg_data: entry_count
//
// An update walks from the leaf up to the root, one tree level per cycle,
// reading the sibling while the parent is written on the node RAM.
// A range count reads at most two nodes per level over up to log2(MAX_ENTRIES) + 1
// levels, since both range edges share the single read port.
// After reset a clearing pass writes zero to all 2*MAX_ENTRIES nodes, one per cycle,
// with s_tready low; configuration writes are taken throughout.
// A result waiting in the output register does not block the next request; only the
// completion of that next request waits for m_tready.
module segment_tree_parity_count #(
    parameter int MAX_ENTRIES = 1024
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // Request channel.
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // s_tdata: position[9:0], new_value[41:10], range_lo[51:42], range_hi[61:52]
    input  logic [stpc_pkg::IN_DATA_W-1:0]   s_tdata,
    // s_tuser: req_type[1:0]
    input  logic [stpc_pkg::IN_USER_W-1:0]   s_tuser,
    // Result channel.
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // m_tdata: count[10:0]
    output logic [stpc_pkg::OUT_DATA_W-1:0]  m_tdata,
    // m_tuser: status[0]
    output logic [stpc_pkg::OUT_USER_W-1:0]  m_tuser,
    // Configuration channel.
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [stpc_pkg::CFG_W-1:0]       cfg_data
);

    import stpc_pkg::*;

    localparam int DEPTH = 2 * MAX_ENTRIES;
    localparam int AW    = $clog2(DEPTH);
    localparam int NW    = $clog2(DEPTH + 1);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_UPD_LEAF,
        ST_UPD_UP,
        ST_Q_A,
        ST_Q_B,
        ST_Q_FIN,
        ST_DONE
    } state_t;

    state_t             state_reg;
    logic [AW-1:0]      clr_reg;
    logic [CFG_W-1:0]   cfg_reg;
    logic [NW-1:0]      cur_reg;
    logic [COUNT_W-1:0] val_reg;
    logic [NW-1:0]      a_reg;
    logic [NW-1:0]      b_reg;
    logic [COUNT_W-1:0] sum_reg;
    logic [COUNT_W-1:0] len_reg;
    logic               odd_reg;
    logic               pend_reg;
    logic [COUNT_W-1:0] res_count_reg;
    logic               res_status_reg;
    logic               m_tvalid_reg;
    logic [COUNT_W-1:0] m_count_reg;
    logic               m_status_reg;

    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [COUNT_W-1:0] ram_wdata;
    logic [AW-1:0]      ram_raddr;
    logic [COUNT_W-1:0] ram_rdata;

    logic [NW-1:0]      parent;
    logic [COUNT_W-1:0] up_sum_next;
    logic [COUNT_W-1:0] sum_next;
    logic [NW-1:0]      b_dec_next;
    logic [CFG_W-1:0]   n_eff;
    logic               m_load;

    logic [REQ_W-1:0]   in_type;
    logic [POS_W-1:0]   in_pos;
    logic [VAL_W-1:0]   in_val;
    logic [POS_W-1:0]   in_lo;
    logic [POS_W-1:0]   in_hi;

    // Request field unpacking.
    assign in_type = s_tuser[REQ_W-1:0];
    assign in_pos  = s_tdata[POS_LSB +: POS_W];
    assign in_val  = s_tdata[VAL_LSB +: VAL_W];
    assign in_lo   = s_tdata[LO_LSB +: POS_W];
    assign in_hi   = s_tdata[HI_LSB +: POS_W];

    // Entries in use, limited to the tree size.
    assign n_eff = (32'(cfg_reg) > 32'(MAX_ENTRIES)) ? CFG_W'(MAX_ENTRIES) : cfg_reg;

    // Handshake and result outputs.
    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = OUT_DATA_W'(m_count_reg);
    assign m_tuser   = m_status_reg;

    // A finished result moves into the output register once that register is free.
    assign m_load = (state_reg == ST_DONE) && (!m_tvalid_reg || m_tready);

    // Tree walk arithmetic.
    assign parent      = cur_reg >> 1;
    assign up_sum_next = val_reg + ram_rdata;
    assign sum_next    = sum_reg + (pend_reg ? ram_rdata : COUNT_W'(0));
    assign b_dec_next  = b_reg[0] ? (b_reg - NW'(1)) : b_reg;

    // Node RAM port control for each state.
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = AW'(cur_reg);
        ram_wdata = val_reg;
        ram_raddr = AW'(cur_reg ^ NW'(1));
        case (state_reg)
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = '0;
            end
            ST_UPD_LEAF: begin
                ram_we = 1'b1;
            end
            ST_UPD_UP: begin
                ram_we    = 1'b1;
                ram_waddr = AW'(parent);
                ram_wdata = up_sum_next;
                ram_raddr = AW'(parent ^ NW'(1));
            end
            ST_Q_A: begin
                ram_raddr = AW'(a_reg);
            end
            ST_Q_B: begin
                ram_raddr = AW'(b_reg - NW'(1));
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    stpc_ram #(
        .WIDTH (COUNT_W),
        .DEPTH (DEPTH)
    ) u_node_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Sequencer: clearing pass, decode, tree walks and the output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_reg      <= '0;
            cfg_reg      <= CFG_RESET;
            pend_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                cfg_reg <= cfg_data;
            end

            // Output register: load a finished result, or clear once it is taken.
            if (m_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end

            case (state_reg)
                ST_CLEAR: begin
                    clr_reg <= clr_reg + AW'(1);
                    if (clr_reg == AW'(DEPTH - 1)) begin
                        state_reg <= ST_IDLE;
                    end
                end

                ST_IDLE: begin
                    if (s_tvalid) begin
                        res_count_reg  <= '0;
                        res_status_reg <= STATUS_ERR;
                        sum_reg        <= '0;
                        pend_reg       <= 1'b0;
                        case (in_type)
                            REQ_UPDATE: begin
                                if (CFG_W'(in_pos) < n_eff) begin
                                    cur_reg   <= NW'(in_pos) + NW'(MAX_ENTRIES);
                                    val_reg   <= {{(COUNT_W-1){1'b0}}, ~in_val[0]};
                                    state_reg <= ST_UPD_LEAF;
                                end else begin
                                    state_reg <= ST_DONE;
                                end
                            end
                            REQ_EVEN, REQ_ODD: begin
                                if ((in_lo <= in_hi) && (CFG_W'(in_hi) < n_eff)) begin
                                    a_reg     <= NW'(in_lo) + NW'(MAX_ENTRIES);
                                    b_reg     <= NW'(in_hi) + NW'(MAX_ENTRIES) + NW'(1);
                                    len_reg   <= COUNT_W'(in_hi) - COUNT_W'(in_lo)
                                                 + COUNT_W'(1);
                                    odd_reg   <= (in_type == REQ_ODD);
                                    state_reg <= ST_Q_A;
                                end else begin
                                    state_reg <= ST_DONE;
                                end
                            end
                            default: begin
                                state_reg <= ST_DONE;
                            end
                        endcase
                    end
                end

                // Leaf written; its sibling is being read.
                ST_UPD_LEAF: begin
                    state_reg <= ST_UPD_UP;
                end

                // One level per cycle: write the parent, read the parent's sibling.
                ST_UPD_UP: begin
                    val_reg <= up_sum_next;
                    cur_reg <= parent;
                    if (parent == NW'(1)) begin
                        res_count_reg  <= '0;
                        res_status_reg <= STATUS_OK;
                        state_reg      <= ST_DONE;
                    end
                end

                // Left edge of the range at this level.
                ST_Q_A: begin
                    sum_reg <= sum_next;
                    if (a_reg < b_reg) begin
                        pend_reg <= a_reg[0];
                        if (a_reg[0]) begin
                            a_reg <= a_reg + NW'(1);
                        end
                        state_reg <= ST_Q_B;
                    end else begin
                        pend_reg  <= 1'b0;
                        state_reg <= ST_Q_FIN;
                    end
                end

                // Right edge of the range, then move both edges up a level.
                ST_Q_B: begin
                    sum_reg   <= sum_next;
                    pend_reg  <= b_reg[0];
                    a_reg     <= a_reg >> 1;
                    b_reg     <= b_dec_next >> 1;
                    state_reg <= ST_Q_A;
                end

                ST_Q_FIN: begin
                    res_count_reg  <= odd_reg ? (len_reg - sum_next) : sum_next;
                    res_status_reg <= STATUS_OK;
                    state_reg      <= ST_DONE;
                end

                // Hand the result over once the output register is free.
                ST_DONE: begin
                    if (m_load) begin
                        m_count_reg  <= res_count_reg;
                        m_status_reg <= res_status_reg;
                        state_reg    <= ST_IDLE;
                    end
                end

                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // A failed request never reports a count.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && (m_status_reg == STATUS_ERR)) |-> (m_count_reg == '0))
        else $error("error result carries a nonzero count");

    // The even count of a range never exceeds the range length.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_Q_FIN) |-> (sum_next <= len_reg))
        else $error("range sum exceeds range length");

    // The upward walk never starts from the root node.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_UPD_UP) |-> (cur_reg >= NW'(2)))
        else $error("update walk above the root");

endmodule

// ===== rtl/stpc_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with registered read data.
module stpc_ram #(
    parameter int WIDTH = 11,
    parameter int DEPTH = 2048
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
